### hdl/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

    // Operation codes carried in the opcode field.
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_MEMBER = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Width of the position field and of the reported count.
    localparam int POS_W = 5;

    // One operation as it arrives on the input channel.
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [POS_W-1:0]   position;
    } t_in;

    // One result as it leaves on the output channel.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [POS_W-1:0]   item_count;
        logic               found;
        logic               sorted;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic set_bad;
        logic set_full;
        logic shift_start;
        logic shift_rd;
        logic shift_wr;
        logic put;
        logic cnt_inc;
        logic cnt_dec;
        logic rd_issue;
        logic rd_capture;
        logic scan_start;
        logic scan_rd;
        logic scan_cmp;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       pos_bad;
        logic       full;
        logic       shift_empty;
        logic       shift_last;
        logic       scan_end;
        logic       out_free;
    } t_dp_sts;

endpackage

### hdl/positional_list_engine_core.sv
`timescale 1ns / 1ps
// Positional list engine: an ordered list of up to DEPTH signed 32-bit values.
// Input channel (i_in_valid, o_in_stall, i_in_data) carries one operation per
// transaction: insert, remove, read, member query or clear, with a 1-based
// position. Output channel (o_out_valid, i_out_stall, o_out_data) returns one
// result per operation: status, read value, count, found and sorted flags.
// One operation is processed at a time; o_in_stall is high while it runs.
// An insert or remove moves each shifted entry by reading it from the entry
// memory and then writing it back one place over, and every operation ends
// with the sorted and member scan, which reads each entry below the count once.
// The result sits in an output register, so the next transaction is accepted
// while a finished result waits; a stalled result holds its data, and the
// next operation waits before loading its own result.
// Synchronous active-low reset empties the list and drops any pending result;
// entry storage is not cleared, only entries below the count are read.
module positional_list_engine_core
    import ple_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    ple_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // Entry storage, count and result registers.
    ple_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### hdl/ple_ctrl.sv
`timescale 1ns / 1ps

module ple_ctrl
    import ple_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_SH_RD   = 4'd2;
    localparam logic [3:0] S_SH_WR   = 4'd3;
    localparam logic [3:0] S_PUT     = 4'd4;
    localparam logic [3:0] S_RD_CAP  = 4'd5;
    localparam logic [3:0] S_SC_INIT = 4'd6;
    localparam logic [3:0] S_SC_RD   = 4'd7;
    localparam logic [3:0] S_SC_CMP  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // New transactions are taken only while no operation is in progress.
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_SC_INIT;
                case (i_sts.op)
                    OP_INSERT: begin
                        if (i_sts.pos_bad) begin
                            o_cmd.set_bad = 1'b1;
                        end else if (i_sts.full) begin
                            o_cmd.set_full = 1'b1;
                        end else if (i_sts.shift_empty) begin
                            n_state = S_PUT;
                        end else begin
                            o_cmd.shift_start = 1'b1;
                            n_state           = S_SH_RD;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_sts.pos_bad) begin
                            o_cmd.set_bad = 1'b1;
                        end else if (i_sts.shift_empty) begin
                            o_cmd.cnt_dec = 1'b1;
                        end else begin
                            o_cmd.shift_start = 1'b1;
                            n_state           = S_SH_RD;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.pos_bad) begin
                            o_cmd.set_bad = 1'b1;
                        end else begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_RD_CAP;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                        n_state = S_SC_INIT;
                    end
                endcase
            end
            S_SH_RD: begin
                o_cmd.shift_rd = 1'b1;
                n_state        = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.shift_wr = 1'b1;
                if (!i_sts.shift_last) begin
                    n_state = S_SH_RD;
                end else if (i_sts.op == OP_INSERT) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_SC_INIT;
                end
            end
            S_PUT: begin
                o_cmd.put     = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_SC_INIT;
            end
            S_RD_CAP: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_SC_INIT;
            end
            S_SC_INIT: begin
                o_cmd.scan_start = 1'b1;
                n_state          = S_SC_RD;
            end
            S_SC_RD: begin
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_SC_CMP;
                end
            end
            S_SC_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = S_SC_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/ple_dpath.sv
`timescale 1ns / 1ps

module ple_dpath
    import ple_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_in_data,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_out    o_out_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Entry storage, one write and one registered read per cycle.
    logic [31:0]        r_mem [DEPTH];
    logic [31:0]        r_rd_data;

    // Current operation and list state.
    logic [2:0]         r_op;
    logic signed [31:0] r_val;
    logic [POS_W-1:0]   r_pos;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [31:0]        r_prev;
    logic [1:0]         r_status;
    logic [31:0]        r_read_value;
    logic               r_found;
    logic               r_sorted;
    logic               r_out_vld;
    t_out               r_out;

    logic [XW-1:0]      w_cnt_x;
    logic [XW-1:0]      w_pos_x;
    logic [XW-1:0]      w_idx_x;
    logic [XW-1:0]      w_pos_m1;
    logic [CW-1:0]      w_idx_m1;
    logic               w_is_ins;
    logic               w_rd_en;
    logic [IW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic [IW-1:0]      w_wr_addr;
    logic [31:0]        w_wr_data;

    assign w_cnt_x  = XW'(r_count);
    assign w_pos_x  = XW'(r_pos);
    assign w_idx_x  = XW'(r_idx);
    assign w_pos_m1 = w_pos_x - XW'(1);
    assign w_idx_m1 = r_idx - CW'(1);
    assign w_is_ins = (r_op == OP_INSERT);

    // Position checks and loop bounds for the controller.
    always_comb begin
        o_sts.op = r_op;
        case (r_op)
            OP_INSERT: o_sts.pos_bad = (r_pos == '0) || (w_pos_x > (w_cnt_x + XW'(1)));
            OP_REMOVE: o_sts.pos_bad = (r_pos == '0) || (w_pos_x > w_cnt_x);
            OP_READ:   o_sts.pos_bad = (r_pos == '0) || (w_pos_x > w_cnt_x);
            default:   o_sts.pos_bad = 1'b0;
        endcase
        o_sts.full        = (w_cnt_x >= XW'(DEPTH));
        o_sts.shift_empty = w_is_ins ? (w_cnt_x < w_pos_x) : (w_pos_x >= w_cnt_x);
        o_sts.shift_last  = w_is_ins ? (w_idx_x <= w_pos_x)
                                     : ((w_idx_x + XW'(1)) >= w_cnt_x);
        o_sts.scan_end    = (w_idx_x >= w_cnt_x);
        o_sts.out_free    = !r_out_vld || !i_out_stall;
    end

    // Memory read address: shift source, read position or scan pointer.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        if (i_cmd.shift_rd) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_is_ins ? w_idx_m1[IW-1:0] : r_idx[IW-1:0];
        end else if (i_cmd.rd_issue) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_pos_m1[IW-1:0];
        end else if (i_cmd.scan_rd) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_idx[IW-1:0];
        end
    end

    // Memory write: a shifted entry, or the new value at its position.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = r_rd_data;
        if (i_cmd.shift_wr) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_is_ins ? r_idx[IW-1:0] : w_idx_m1[IW-1:0];
        end else if (i_cmd.put) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_pos_m1[IW-1:0];
            w_wr_data = r_val;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Stored count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Operation capture, loop pointer and result accumulation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_in_data.opcode;
            r_val        <= i_in_data.value;
            r_pos        <= i_in_data.position;
            r_status     <= ST_OK;
            r_read_value <= '0;
        end
        if (i_cmd.set_bad) begin
            r_status <= ST_BAD_POS;
        end
        if (i_cmd.set_full) begin
            r_status <= ST_FULL;
        end
        if (i_cmd.rd_capture) begin
            r_read_value <= r_rd_data;
        end
        if (i_cmd.shift_start) begin
            r_idx <= w_is_ins ? r_count : w_pos_x[CW-1:0];
        end else if (i_cmd.shift_wr) begin
            r_idx <= w_is_ins ? w_idx_m1 : (r_idx + CW'(1));
        end else if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_cmp) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.scan_start) begin
            r_found  <= 1'b0;
            r_sorted <= 1'b1;
        end else if (i_cmd.scan_cmp) begin
            r_prev <= r_rd_data;
            if ((r_op == OP_MEMBER) && (r_rd_data == r_val)) begin
                r_found <= 1'b1;
            end
            if ((r_idx != '0) && ($signed(r_prev) > $signed(r_rd_data))) begin
                r_sorted <= 1'b0;
            end
        end
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status     <= r_status;
            r_out.read_value <= r_read_value;
            r_out.item_count <= w_cnt_x[POS_W-1:0];
            r_out.found      <= r_found;
            r_out.sorted     <= r_sorted;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

### hdl/ple_checker.sv
`timescale 1ns / 1ps

module ple_checker
    import ple_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_stall,
    input t_out i_out_data,
    input logic i_out_valid,
    input logic i_out_stall
);

    // A stalled result keeps its valid and its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

    // An accepted transaction makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall) |=> i_in_stall)
        else $error("input not stalled after an accepted transaction");

    // A failed operation reports no read value and no match.
    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_data.status != ST_OK))
            |-> ((i_out_data.read_value == '0) && !i_out_data.found))
        else $error("error result carries data");

    // A full list refusal only happens at full count.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_data.status == ST_FULL))
            |-> (i_out_data.item_count == POS_W'(DEPTH)))
        else $error("list full reported below capacity");

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind positional_list_engine_core ple_checker #(
    .DEPTH (DEPTH)
) u_ple_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_data  (o_out_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);
